### sv/dctw_pkg.sv
// Shared types, constants and helper functions for the DMA chain tag walker.
package dctw_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 160;
    localparam int unsigned S_TUSER_W   = 1;
    localparam int unsigned M_TDATA_W   = 184;
    localparam int unsigned M_TUSER_W   = 4;
    localparam int unsigned STACK_DEPTH_DEF = 2;

    localparam logic [ADDR_W-1:0] ADDR_LOW  = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] ADDR_HIGH = 32'h0200_0000;
    localparam logic [ADDR_W-1:0] QWORD_BYTES = 32'd16;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_TAG_XFER = 2'd0;
    localparam logic [1:0] REG_VIF_EN   = 2'd1;
    localparam logic [1:0] REG_GIF_EN   = 2'd2;
    localparam logic [1:0] REG_SKIP     = 2'd3;

    // Input item kinds.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [2:0] {
        TAG_REFE = 3'd0,
        TAG_CNT  = 3'd1,
        TAG_NEXT = 3'd2,
        TAG_REF  = 3'd3,
        TAG_REFS = 3'd4,
        TAG_CALL = 3'd5,
        TAG_RET  = 3'd6,
        TAG_END  = 3'd7
    } tag_id_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CALL_OVF = 2'd1,
        ERR_RET_UNF  = 2'd2,
        ERR_ADDR     = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        FWD_NONE = 2'd0,
        FWD_VIF  = 2'd1,
        FWD_GIF  = 2'd2
    } fwd_target_t;

    typedef enum logic [1:0] {
        FIRST_ALL   = 2'd0,
        FIRST_UPPER = 2'd2
    } fwd_first_t;

    typedef struct packed {
        logic tag_xfer_en;
        logic vif_en;
        logic gif_en;
        logic skip_data;
    } cfg_t;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] start_addr;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  tag_addr;
        logic [ADDR_W-1:0]  data_addr;
        logic [COUNT_W-1:0] quad_count;
        tag_id_t            last_id;
        logic               stopped;
        err_code_t          err;
    } walk_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  fetch_addr;
        logic               fetch_valid;
        fwd_target_t        forward_target;
        fwd_first_t         forward_first;
        logic [WORD_W-1:0]  out_word0;
        logic [WORD_W-1:0]  out_word1;
        logic [WORD_W-1:0]  out_word2;
        logic [WORD_W-1:0]  out_word3;
        tag_id_t            current_tag;
        logic [COUNT_W-1:0] remaining_count;
        logic               chain_done;
        err_code_t          error_code;
    } result_t;

    function automatic logic addr_bad(input logic [ADDR_W-1:0] a);
        addr_bad = (a < ADDR_LOW) || (a > ADDR_HIGH);
    endfunction

    // Byte length of a block of quadwords, zero-extended to the address width.
    function automatic logic [ADDR_W-1:0] qw_bytes(input logic [COUNT_W-1:0] n);
        qw_bytes = {{(ADDR_W-COUNT_W-4){1'b0}}, n, 4'b0000};
    endfunction

endpackage

### sv/dctw_step.sv
// Next-state and result logic for one item of the chain walker.
module dctw_step #(
    parameter int unsigned STACK_DEPTH = dctw_pkg::STACK_DEPTH_DEF,
    parameter int unsigned LVL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  dctw_pkg::cfg_t               cfg,
    input  dctw_pkg::in_item_t           item,
    input  dctw_pkg::walk_state_t        state,
    input  logic [LVL_W-1:0]             level,
    input  logic [dctw_pkg::ADDR_W-1:0]  stack_rd_data,
    output dctw_pkg::walk_state_t        state_next,
    output logic [LVL_W-1:0]             level_next,
    output logic                         push_en,
    output logic [dctw_pkg::ADDR_W-1:0]  push_data,
    output dctw_pkg::result_t            result
);
    import dctw_pkg::*;

    localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(STACK_DEPTH);

    logic [ADDR_W-1:0] next16;
    logic [ADDR_W-1:0] tag_span;
    logic              data_on;
    tag_id_t           id;

    always_comb
    begin
        next16   = state.tag_addr + QWORD_BYTES;
        tag_span = qw_bytes(item.word0[COUNT_W-1:0]);
        data_on  = cfg.vif_en || cfg.gif_en;
        id       = tag_id_t'(item.word0[30:28]);

        state_next = state;
        level_next = level;
        push_en    = 1'b0;
        push_data  = next16 + tag_span;
        result     = '0;

        if (item.operation == OP_START)
        begin
            state_next.stopped    = 1'b0;
            state_next.quad_count = '0;
            state_next.err        = ERR_NONE;
            state_next.tag_addr   = item.start_addr;
            level_next            = '0;
        end
        else if (!state.stopped)
        begin
            if (state.quad_count == '0)
            begin
                // The fetched quadword is a tag.
                if (addr_bad(state.tag_addr))
                begin
                    state_next.stopped = 1'b1;
                    state_next.err     = ERR_ADDR;
                end
                else
                begin
                    state_next.last_id    = id;
                    state_next.quad_count = item.word0[COUNT_W-1:0];
                    if (cfg.vif_en && cfg.tag_xfer_en)
                    begin
                        result.forward_target = FWD_VIF;
                        result.forward_first  = FIRST_UPPER;
                        result.out_word2      = item.word2;
                        result.out_word3      = item.word3;
                    end
                    case (id)
                        TAG_CNT:
                        begin
                            state_next.data_addr = next16;
                            state_next.tag_addr  = next16 + tag_span;
                        end
                        TAG_REF, TAG_REFE, TAG_REFS:
                        begin
                            state_next.data_addr = item.word1;
                            state_next.tag_addr  = next16;
                        end
                        TAG_NEXT:
                        begin
                            state_next.data_addr = next16;
                            state_next.tag_addr  = item.word1;
                        end
                        TAG_CALL:
                        begin
                            if (level >= DEPTH_LVL)
                            begin
                                state_next.stopped = 1'b1;
                                state_next.err     = ERR_CALL_OVF;
                            end
                            else
                            begin
                                state_next.data_addr = next16;
                                state_next.tag_addr  = item.word1;
                                push_en              = 1'b1;
                                level_next           = level + 1'b1;
                            end
                        end
                        TAG_RET:
                        begin
                            if (level == '0 || level > DEPTH_LVL)
                            begin
                                state_next.stopped = 1'b1;
                                state_next.err     = ERR_RET_UNF;
                            end
                            else
                            begin
                                state_next.data_addr = next16;
                                state_next.tag_addr  = stack_rd_data;
                                level_next           = level - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next.data_addr = next16;
                        end
                    endcase
                end
            end
            else if (cfg.skip_data)
            begin
                // The whole data block is passed over in one step.
                state_next.data_addr  = state.data_addr + qw_bytes(state.quad_count);
                state_next.quad_count = '0;
            end
            else if (data_on && addr_bad(state.data_addr))
            begin
                state_next.stopped = 1'b1;
                state_next.err     = ERR_ADDR;
            end
            else
            begin
                state_next.data_addr  = state.data_addr + QWORD_BYTES;
                state_next.quad_count = state.quad_count - 1'b1;
                if (data_on)
                begin
                    result.forward_target = cfg.vif_en ? FWD_VIF : FWD_GIF;
                    result.forward_first  = FIRST_ALL;
                    result.out_word0      = item.word0;
                    result.out_word1      = item.word1;
                    result.out_word2      = item.word2;
                    result.out_word3      = item.word3;
                end
            end

            if (!state_next.stopped && state_next.quad_count == '0 &&
                (state_next.last_id == TAG_END || state_next.last_id == TAG_REFE))
            begin
                state_next.stopped = 1'b1;
            end
        end

        if (!state_next.stopped)
        begin
            if (state_next.quad_count == '0)
            begin
                result.fetch_addr  = state_next.tag_addr;
                result.fetch_valid = 1'b1;
            end
            else if (!cfg.skip_data && data_on)
            begin
                result.fetch_addr  = state_next.data_addr;
                result.fetch_valid = 1'b1;
            end
        end
        result.current_tag     = state_next.last_id;
        result.remaining_count = state_next.quad_count;
        result.chain_done      = state_next.stopped;
        result.error_code      = state_next.err;
    end

endmodule

### sv/dma_chain_tag_walker.sv
// Top level of the source-chain DMA tag walker: handshakes, state and config registers.
//
//  Port group   Dir   Contents
//  s_*          in    item beat: tuser = operation, tdata = start_addr, word0..word3
//  m_*          out   result beat: tuser = forward target/first, tdata = status and words
//  p*           in    APB register port, four one-bit registers at 0x0, 0x4, 0x8, 0xC
//
// Each item is captured in the input register and then decoded into the output
// register; one beat is taken per cycle while the result side is not stalled.
// The walker state updates as an item moves into the output register.
// A stalled result holds in the output register while one more beat waits in the
// input register. Reset leaves the chain stopped until a start beat arrives.
module dma_chain_tag_walker #(
    parameter int unsigned STACK_DEPTH = dctw_pkg::STACK_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] start_addr, [63:32] word0, [95:64] word1, [127:96] word2, [159:128] word3
    input  logic [dctw_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] operation
    input  logic [dctw_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] fetch_addr, [32] fetch_valid, [64:33] out_word0, [96:65] out_word1,
    // [128:97] out_word2, [160:129] out_word3, [163:161] current_tag,
    // [179:164] remaining_count, [180] chain_done, [182:181] error_code, [183] zero
    output logic [dctw_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] forward_target, [3:2] forward_first
    output logic [dctw_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dctw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dctw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dctw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import dctw_pkg::*;

    localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    in_item_t          in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           step_result;
    walk_state_t       state_reg;
    walk_state_t       state_next;
    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    logic [ADDR_W-1:0] stack_reg [STACK_DEPTH];
    logic [LVL_W-1:0]  level_dec;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic              push_en;
    logic [ADDR_W-1:0] push_data;
    logic              out_adv;
    logic              step_fire;
    logic              in_accept;
    logic              cfg_write;

    // APB register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TAG_XFER: cfg_next.tag_xfer_en = pwdata[0];
                REG_VIF_EN:   cfg_next.vif_en      = pwdata[0];
                REG_GIF_EN:   cfg_next.gif_en      = pwdata[0];
                REG_SKIP:     cfg_next.skip_data   = pwdata[0];
                default:      cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_TAG_XFER: prdata[0] = cfg_reg.tag_xfer_en;
            REG_VIF_EN:   prdata[0] = cfg_reg.vif_en;
            REG_GIF_EN:   prdata[0] = cfg_reg.gif_en;
            REG_SKIP:     prdata[0] = cfg_reg.skip_data;
            default:      prdata    = '0;
        endcase
    end

    // Two-register pipeline; the input register drains whenever the output one can load.
    assign out_adv   = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Return stack: pushes go to the current level, pops read the entry below it.
    assign level_dec = level_reg - 1'b1;
    assign rd_idx    = level_dec[IDX_W-1:0];
    assign wr_idx    = level_reg[IDX_W-1:0];

    dctw_step #(
        .STACK_DEPTH (STACK_DEPTH),
        .LVL_W       (LVL_W)
    ) u_step (
        .cfg           (cfg_reg),
        .item          (in_item_reg),
        .state         (state_reg),
        .level         (level_reg),
        .stack_rd_data (stack_reg[rd_idx]),
        .state_next    (state_next),
        .level_next    (level_next),
        .push_en       (push_en),
        .push_data     (push_data),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{tag_addr: '0, data_addr: '0, quad_count: '0,
                               last_id: TAG_REFE, stopped: 1'b1, err: ERR_NONE};
            level_reg     <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
            begin
                state_reg <= state_next;
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.operation  <= s_tuser[0];
            in_item_reg.start_addr <= s_tdata[31:0];
            in_item_reg.word0      <= s_tdata[63:32];
            in_item_reg.word1      <= s_tdata[95:64];
            in_item_reg.word2      <= s_tdata[127:96];
            in_item_reg.word3      <= s_tdata[159:128];
        end
        if (step_fire)
        begin
            out_reg <= step_result;
        end
        if (step_fire && push_en)
        begin
            stack_reg[wr_idx] <= push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_reg.error_code,
                       out_reg.chain_done,
                       out_reg.remaining_count,
                       out_reg.current_tag,
                       out_reg.out_word3,
                       out_reg.out_word2,
                       out_reg.out_word1,
                       out_reg.out_word0,
                       out_reg.fetch_valid,
                       out_reg.fetch_addr};
    assign m_tuser  = {out_reg.forward_first, out_reg.forward_target};

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("return stack level beyond its depth");

    a_running_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.stopped |-> state_reg.err == ERR_NONE)
        else $error("chain running with an error code set");

    a_fetch_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.fetch_valid |-> !out_reg.chain_done)
        else $error("fetch requested by a stopped chain");

    a_no_fwd_no_words: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.forward_target == FWD_NONE |->
            out_reg.forward_first == FIRST_ALL && out_reg.out_word0 == '0 &&
            out_reg.out_word2 == '0 && out_reg.out_word3 == '0)
        else $error("words present on a beat with no forward target");

endmodule

### verif/tag_walk_checker.sv
`timescale 1ns / 100ps
// Checker for the DMA chain tag walker: predicts every result beat and compares it.
module tag_walk_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // [31:0] start_addr, [63:32] word0, [95:64] word1, [127:96] word2, [159:128] word3
    input  logic [dctw_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic [dctw_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] fetch_addr, [32] fetch_valid, [64:33] out_word0, [96:65] out_word1,
    // [128:97] out_word2, [160:129] out_word3, [163:161] current_tag,
    // [179:164] remaining_count, [180] chain_done, [182:181] error_code
    input  logic [dctw_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] forward_target, [3:2] forward_first
    input  logic [dctw_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dctw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dctw_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [dctw_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending
);
    import dctw_pkg::*;

    localparam int unsigned RET_DEPTH = STACK_DEPTH_DEF;

    logic [ADDR_W-1:0]  tag_addr;
    logic [ADDR_W-1:0]  data_addr;
    logic [COUNT_W-1:0] quads_left;
    tag_id_t            last_id;
    logic [ADDR_W-1:0]  ret_stack [RET_DEPTH];
    int unsigned        ret_level;
    logic               stopped;
    err_code_t          err;

    logic cfg_tag_xfer;
    logic cfg_vif;
    logic cfg_gif;
    logic cfg_skip;
    logic reg_value;

    result_t     status_q [$];
    result_t     got;
    result_t     want;
    int unsigned beat_no;

    function automatic logic outside_window(input logic [ADDR_W-1:0] a);
        outside_window = (a < ADDR_LOW) || (a > ADDR_HIGH);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t: result beat %0d, %s: got %h, want %h", $time, beat_no, what,
                 got_v, want_v);
        fail_count++;
    endtask

    // Walks the chain by one input beat and returns the status beat it causes.
    task automatic advance_walker(input logic op, input logic [31:0] start,
                                  input logic [31:0] w0, input logic [31:0] w1,
                                  input logic [31:0] w2, input logic [31:0] w3,
                                  output result_t r);
        logic [ADDR_W-1:0] after_tag;
        logic [ADDR_W-1:0] block_bytes;
        logic              to_dest;
        r = '0;
        to_dest = cfg_vif || cfg_gif;
        if (op == OP_START) begin
            stopped = 1'b0;
            ret_level = 0;
            quads_left = '0;
            err = ERR_NONE;
            tag_addr = start;
        end
        else if (!stopped) begin
            if (quads_left == '0) begin
                if (outside_window(tag_addr)) begin
                    stopped = 1'b1;
                    err = ERR_ADDR;
                end
                else begin
                    last_id = tag_id_t'(w0[30:28]);
                    quads_left = w0[15:0];
                    if (cfg_vif && cfg_tag_xfer) begin
                        r.forward_target = FWD_VIF;
                        r.forward_first = FIRST_UPPER;
                        r.out_word2 = w2;
                        r.out_word3 = w3;
                    end
                    after_tag = tag_addr + QWORD_BYTES;
                    block_bytes = {12'h000, quads_left, 4'h0};
                    case (last_id)
                        TAG_CNT:
                        begin
                            data_addr = after_tag;
                            tag_addr = after_tag + block_bytes;
                        end
                        TAG_REFE, TAG_REF, TAG_REFS:
                        begin
                            data_addr = w1;
                            tag_addr = after_tag;
                        end
                        TAG_NEXT:
                        begin
                            data_addr = after_tag;
                            tag_addr = w1;
                        end
                        TAG_CALL:
                        begin
                            if (ret_level >= RET_DEPTH) begin
                                stopped = 1'b1;
                                err = ERR_CALL_OVF;
                            end
                            else begin
                                data_addr = after_tag;
                                ret_stack[ret_level] = after_tag + block_bytes;
                                ret_level++;
                                tag_addr = w1;
                            end
                        end
                        TAG_RET:
                        begin
                            if (ret_level == 0) begin
                                stopped = 1'b1;
                                err = ERR_RET_UNF;
                            end
                            else begin
                                data_addr = after_tag;
                                ret_level--;
                                tag_addr = ret_stack[ret_level];
                            end
                        end
                        default:
                        begin
                            data_addr = after_tag;
                        end
                    endcase
                end
            end
            else if (cfg_skip) begin
                data_addr = data_addr + {12'h000, quads_left, 4'h0};
                quads_left = '0;
            end
            else if (to_dest && outside_window(data_addr)) begin
                stopped = 1'b1;
                err = ERR_ADDR;
            end
            else begin
                data_addr = data_addr + QWORD_BYTES;
                quads_left = quads_left - 16'd1;
                if (to_dest) begin
                    r.forward_target = cfg_vif ? FWD_VIF : FWD_GIF;
                    r.forward_first = FIRST_ALL;
                    r.out_word0 = w0;
                    r.out_word1 = w1;
                    r.out_word2 = w2;
                    r.out_word3 = w3;
                end
            end
            // The chain ends once the data of an END or REFE tag is used up.
            if (!stopped && quads_left == '0 && (last_id == TAG_END || last_id == TAG_REFE))
                stopped = 1'b1;
        end
        if (!stopped) begin
            if (quads_left == '0) begin
                r.fetch_addr = tag_addr;
                r.fetch_valid = 1'b1;
            end
            else if (!cfg_skip && to_dest) begin
                r.fetch_addr = data_addr;
                r.fetch_valid = 1'b1;
            end
        end
        r.current_tag = last_id;
        r.remaining_count = quads_left;
        r.chain_done = stopped;
        r.error_code = err;
    endtask

    task automatic check_beat(input result_t g, input result_t w);
        if (g.fetch_addr !== w.fetch_addr)
            report_mismatch("fetch_addr", g.fetch_addr, w.fetch_addr);
        if (g.fetch_valid !== w.fetch_valid)
            report_mismatch("fetch_valid", 32'(g.fetch_valid), 32'(w.fetch_valid));
        if (g.forward_target !== w.forward_target)
            report_mismatch("forward_target", 32'(g.forward_target),
                            32'(w.forward_target));
        if (g.forward_first !== w.forward_first)
            report_mismatch("forward_first", 32'(g.forward_first), 32'(w.forward_first));
        if (g.out_word0 !== w.out_word0)
            report_mismatch("out_word0", g.out_word0, w.out_word0);
        if (g.out_word1 !== w.out_word1)
            report_mismatch("out_word1", g.out_word1, w.out_word1);
        if (g.out_word2 !== w.out_word2)
            report_mismatch("out_word2", g.out_word2, w.out_word2);
        if (g.out_word3 !== w.out_word3)
            report_mismatch("out_word3", g.out_word3, w.out_word3);
        if (g.current_tag !== w.current_tag)
            report_mismatch("current_tag", 32'(g.current_tag), 32'(w.current_tag));
        if (g.remaining_count !== w.remaining_count)
            report_mismatch("remaining_count", 32'(g.remaining_count),
                            32'(w.remaining_count));
        if (g.chain_done !== w.chain_done)
            report_mismatch("chain_done", 32'(g.chain_done), 32'(w.chain_done));
        if (g.error_code !== w.error_code)
            report_mismatch("error_code", 32'(g.error_code), 32'(w.error_code));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tag_addr <= '0;
            data_addr <= '0;
            quads_left <= '0;
            last_id <= TAG_REFE;
            ret_stack[0] <= '0;
            ret_stack[1] <= '0;
            ret_level <= 0;
            stopped <= 1'b1;
            err <= ERR_NONE;
            cfg_tag_xfer <= 1'b0;
            cfg_vif <= 1'b0;
            cfg_gif <= 1'b0;
            cfg_skip <= 1'b0;
            beat_no <= 0;
            fail_count <= 0;
            pending <= 0;
            status_q.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.fetch_addr = m_tdata[31:0];
                got.fetch_valid = m_tdata[32];
                got.out_word0 = m_tdata[64:33];
                got.out_word1 = m_tdata[96:65];
                got.out_word2 = m_tdata[128:97];
                got.out_word3 = m_tdata[160:129];
                got.current_tag = tag_id_t'(m_tdata[163:161]);
                got.remaining_count = m_tdata[179:164];
                got.chain_done = m_tdata[180];
                got.error_code = err_code_t'(m_tdata[182:181]);
                got.forward_target = fwd_target_t'(m_tuser[1:0]);
                got.forward_first = fwd_first_t'(m_tuser[3:2]);
                if (status_q.size() == 0)
                    report_mismatch("beat with nothing pending", got.fetch_addr, '0);
                else begin
                    want = status_q.pop_front();
                    check_beat(got, want);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready) begin
                advance_walker(s_tuser[0], s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                               s_tdata[127:96], s_tdata[159:128], want);
                status_q.push_back(want);
            end
            if (psel && penable && pready) begin
                case (paddr[3:2])
                    REG_TAG_XFER: reg_value = cfg_tag_xfer;
                    REG_VIF_EN:   reg_value = cfg_vif;
                    REG_GIF_EN:   reg_value = cfg_gif;
                    default:      reg_value = cfg_skip;
                endcase
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_TAG_XFER: cfg_tag_xfer = pwdata[0];
                        REG_VIF_EN:   cfg_vif = pwdata[0];
                        REG_GIF_EN:   cfg_gif = pwdata[0];
                        default:      cfg_skip = pwdata[0];
                    endcase
                end
                else if (prdata !== {31'b0, reg_value})
                    report_mismatch("prdata", prdata, {31'b0, reg_value});
            end
            pending <= status_q.size();
        end
    end

endmodule

### verif/dma_chain_tag_walker_tb.sv
`timescale 1ns / 100ps
// Testbench top for the DMA chain tag walker: clock, reset, stimulus and verdict.
module dma_chain_tag_walker_tb;
    import dctw_pkg::*;

    localparam int unsigned IDLE_PCT    = 12;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_BEATS = 200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;

    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned beats_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dma_chain_tag_walker dut (.*);

    tag_walk_checker walk_check (.*);

    initial begin
        #2_000_000;
        $display("dma_chain_tag_walker_tb: done, errors");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [31:0] tag_word(input tag_id_t id, input logic [15:0] count);
        tag_word = {1'b0, id, 12'h000, count};
    endfunction

    task automatic send_beat(input logic op, input logic [31:0] addr, input logic [31:0] w0,
                             input logic [31:0] w1, input logic [31:0] w2,
                             input logic [31:0] w3);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {w3, w2, w1, w0, addr};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic start_beat(input logic [31:0] addr);
        send_beat(OP_START, addr, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic step_beat(input logic [31:0] w0, input logic [31:0] w1);
        send_beat(OP_STEP, $urandom, w0, w1, $urandom, $urandom);
    endtask

    task automatic data_beat();
        send_beat(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Stops offering beats until every predicted status beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Bits are {tag_transfer_enable, vif_enable, gif_enable, skip_data}.
    task automatic load_config(input logic [3:0] bits);
        apb_access(1'b1, REG_TAG_XFER, {31'b0, bits[3]});
        apb_access(1'b1, REG_VIF_EN, {31'b0, bits[2]});
        apb_access(1'b1, REG_GIF_EN, {31'b0, bits[1]});
        apb_access(1'b1, REG_SKIP, {31'b0, bits[0]});
        apb_access(1'b0, REG_TAG_XFER, '0);
        apb_access(1'b0, REG_VIF_EN, '0);
        apb_access(1'b0, REG_GIF_EN, '0);
        apb_access(1'b0, REG_SKIP, '0);
    endtask

    // A mostly well-formed chain: tags followed by the data beats they call for,
    // with the return stack tracked so that only a few calls and returns fail.
    task automatic walk_chain(input logic [3:0] cfg);
        logic [31:0] w0;
        logic [31:0] w1;
        tag_id_t     id;
        int unsigned level;
        int unsigned count;
        int unsigned roll;
        int unsigned tags;
        bit          done;
        start_beat($urandom_range(32'h0180_0000, ADDR_LOW));
        level = 0;
        tags = 0;
        done = 1'b0;
        while (!done && tags < 24) begin
            roll = $urandom_range(99);
            id = tag_id_t'($urandom_range(7));
            if (id == TAG_CALL && level >= STACK_DEPTH_DEF && roll >= 10)
                id = TAG_CNT;
            if (id == TAG_RET && level == 0 && roll >= 10)
                id = TAG_REF;
            if ((id == TAG_END || id == TAG_REFE) && tags < 3 && roll >= 30)
                id = TAG_NEXT;
            count = ($urandom_range(99) < 90) ? $urandom_range(4) : $urandom_range(40);
            w0 = $urandom;
            w0[30:28] = id;
            w0[15:0] = count[15:0];
            roll = $urandom_range(99);
            if (roll < 94)
                w1 = $urandom_range(32'h01F0_0000, ADDR_LOW);
            else if (roll < 97)
                w1 = roll[0] ? ADDR_HIGH : ADDR_LOW;
            else
                w1 = $urandom;
            step_beat(w0, w1);
            tags++;
            if (id == TAG_CALL) begin
                if (level >= STACK_DEPTH_DEF)
                    done = 1'b1;
                else
                    level++;
            end
            if (id == TAG_RET) begin
                if (level == 0)
                    done = 1'b1;
                else
                    level--;
            end
            if (!done) begin
                // With skipping on, a whole data block goes in one step.
                if (cfg[0])
                    count = (count != 0) ? 1 : 0;
                repeat (count) data_beat();
                if (id == TAG_END || id == TAG_REFE)
                    done = 1'b1;
            end
        end
    endtask

    task automatic noise_burst();
        int unsigned n;
        logic        op;
        n = $urandom_range(6, 1);
        repeat (n) begin
            op = ($urandom_range(99) < 20) ? OP_START : OP_STEP;
            send_beat(op, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin : stimulus
        logic [3:0]  phase_cfg [8];
        int unsigned phase_end;
        bit          paused;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= '0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        paused = 1'b0;
        phase_cfg = '{4'b0000, 4'b1111, 4'b0010, 4'b0001,
                      4'b0110, 4'b1010, 4'b1100, 4'b0000};
        phase_cfg[7] = 4'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        load_config(4'b1100);
        // A step before any start leaves the walker idle.
        step_beat(tag_word(TAG_CNT, 16'd1), ADDR_LOW);
        // Tag fetches just below the window and at the top of the address space.
        start_beat(ADDR_LOW - 32'd1);
        step_beat(tag_word(TAG_END, 16'd0), '0);
        start_beat(32'hFFFF_FFFF);
        step_beat(tag_word(TAG_END, 16'd0), '0);
        // A tag at the top of the window puts its data just past it.
        start_beat(ADDR_HIGH);
        step_beat(tag_word(TAG_CNT, 16'd1), '0);
        data_beat();
        // Three nested calls overflow the return stack.
        start_beat(ADDR_LOW);
        step_beat(tag_word(TAG_CALL, 16'd0), ADDR_LOW + 32'h100);
        step_beat(tag_word(TAG_CALL, 16'd0), ADDR_LOW + 32'h200);
        step_beat(tag_word(TAG_CALL, 16'd2), ADDR_LOW + 32'h300);
        // A return with an empty stack.
        start_beat(ADDR_LOW);
        step_beat(tag_word(TAG_RET, 16'd0), '0);
        // Each remaining kind in one chain, ending on END; the last beat is ignored.
        start_beat(ADDR_LOW + 32'h40);
        step_beat(tag_word(TAG_REF, 16'd1), 32'h0020_0000);
        data_beat();
        step_beat(tag_word(TAG_CALL, 16'd1), 32'h0030_0000);
        data_beat();
        step_beat(tag_word(TAG_RET, 16'd0), '0);
        step_beat(tag_word(TAG_NEXT, 16'd0), 32'h0040_0000);
        step_beat(tag_word(TAG_REFS, 16'd1), ADDR_HIGH);
        data_beat();
        step_beat(tag_word(TAG_END, 16'd1), '0);
        data_beat();
        data_beat();
        // REFE with no data stops at once.
        start_beat(ADDR_LOW);
        step_beat(tag_word(TAG_REFE, 16'd0), $urandom);
        drain();

        // Full-size blocks skipped whole, the last one an all-ones END tag.
        load_config(4'b0001);
        start_beat(ADDR_LOW);
        step_beat(tag_word(TAG_CNT, 16'hFFFF), $urandom);
        data_beat();
        step_beat(32'hFFFF_FFFF, $urandom);
        data_beat();

        for (int p = 0; p < 8; p++) begin
            drain();
            load_config(phase_cfg[p]);
            if (p == 1)
                hold_req = 1'b1;
            no_idle = (p == 4);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                if ($urandom_range(99) < 85)
                    walk_chain(phase_cfg[p]);
                else
                    noise_burst();
                if (p == 2 && !paused && beats_sent + PHASE_BEATS / 2 > phase_end) begin
                    paused = 1'b1;
                    drain();
                end
            end
        end
        no_idle = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("dma_chain_tag_walker_tb: done, clean");
        else
            $display("dma_chain_tag_walker_tb: done, errors");
        $finish;
    end

endmodule
